[src/ncs_pkg.sv]
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared types and constants for the NAND command cycle sequencer: bus cycle
// kinds, the standard NAND opcodes that shape a command's tail, and the
// request and bus cycle payload structs.
// ----------------------------------------------------------------------------
package ncs_pkg;

    // Kinds of bus cycle.
    localparam logic [1:0] KindCmd  = 2'd0;
    localparam logic [1:0] KindAddr = 2'd1;
    localparam logic [1:0] KindWait = 2'd2;

    // Standard NAND command set values used by the sequencer.
    localparam logic [7:0] OpRead0       = 8'h00;
    localparam logic [7:0] OpRndOut      = 8'h05;
    localparam logic [7:0] OpPageProg    = 8'h10;
    localparam logic [7:0] OpCachedProg  = 8'h15;
    localparam logic [7:0] OpReadStart   = 8'h30;
    localparam logic [7:0] OpErase1      = 8'h60;
    localparam logic [7:0] OpStatus      = 8'h70;
    localparam logic [7:0] OpSeqIn       = 8'h80;
    localparam logic [7:0] OpRndIn       = 8'h85;
    localparam logic [7:0] OpErase2      = 8'hD0;
    localparam logic [7:0] OpRndOutStart = 8'hE0;

    // Default number of row address bytes (legal range 2 to 3).
    localparam int RowAddrBytesDef = 3;

    // One command request.
    typedef struct packed {
        logic [7:0]  opcode;
        logic [15:0] column;
        logic        column_present;
        logic [23:0] page;
        logic        page_present;
    } t_cmd;

    // One bus cycle.
    typedef struct packed {
        logic [1:0] cycle_kind;
        logic [7:0] bus_byte;
        logic       last;
    } t_cycle;

endpackage

[src/ncs_cycle_gen.sv]
// ----------------------------------------------------------------------------
// ncs_cycle_gen
// Decodes one bus cycle of a command from the held request and the cycle
// index: command latch, column bytes, row bytes, then the opcode tail, and
// flags the final cycle of the command.
// ----------------------------------------------------------------------------
module ncs_cycle_gen #(
    parameter int RowAddrBytes = ncs_pkg::RowAddrBytesDef,
    parameter int StepW        = 3
) (
    input  ncs_pkg::t_cmd     i_cmd,
    input  logic [StepW-1:0]  i_step,
    output ncs_pkg::t_cycle   o_cycle
);

    localparam int CntW = StepW + 1;

    logic [CntW-1:0] w_step;
    logic [CntW-1:0] w_col_n;
    logic [CntW-1:0] w_row_n;
    logic [CntW-1:0] w_tail_n;
    logic [CntW-1:0] w_total;
    logic [CntW-1:0] w_row_off;
    logic [CntW-1:0] w_tail_off;
    logic [1:0]      w_row_idx;

    assign w_step     = CntW'(i_step);
    assign w_col_n    = i_cmd.column_present ? CntW'(2) : '0;
    assign w_row_n    = i_cmd.page_present ? CntW'(RowAddrBytes) : '0;
    assign w_total    = CntW'(1) + w_col_n + w_row_n + w_tail_n;
    assign w_row_off  = w_step - CntW'(1) - w_col_n;
    assign w_tail_off = w_row_off - w_row_n;
    assign w_row_idx  = w_row_off[1:0];

    // Tail length depends on the opcode alone.
    always_comb begin
        unique case (i_cmd.opcode)
            ncs_pkg::OpRead0: begin
                w_tail_n = CntW'(2);
            end
            ncs_pkg::OpRndOut: begin
                w_tail_n = CntW'(1);
            end
            ncs_pkg::OpPageProg, ncs_pkg::OpCachedProg, ncs_pkg::OpErase1,
            ncs_pkg::OpErase2, ncs_pkg::OpSeqIn, ncs_pkg::OpRndIn,
            ncs_pkg::OpStatus: begin
                w_tail_n = '0;
            end
            default: begin
                w_tail_n = CntW'(1);
            end
        endcase
    end

    // Select the cycle at the current index.
    always_comb begin
        o_cycle.last = (w_step == (w_total - CntW'(1)));
        priority if (w_step == '0) begin
            o_cycle.cycle_kind = ncs_pkg::KindCmd;
            o_cycle.bus_byte   = i_cmd.opcode;
        end else if (w_step <= w_col_n) begin
            o_cycle.cycle_kind = ncs_pkg::KindAddr;
            o_cycle.bus_byte   = (w_step == CntW'(1)) ? i_cmd.column[7:0]
                                                      : i_cmd.column[15:8];
        end else if (w_row_off < w_row_n) begin
            o_cycle.cycle_kind = ncs_pkg::KindAddr;
            unique case (w_row_idx)
                2'd0:    o_cycle.bus_byte = i_cmd.page[7:0];
                2'd1:    o_cycle.bus_byte = i_cmd.page[15:8];
                default: o_cycle.bus_byte = i_cmd.page[23:16];
            endcase
        end else if (i_cmd.opcode == ncs_pkg::OpRead0 && w_tail_off == '0) begin
            o_cycle.cycle_kind = ncs_pkg::KindCmd;
            o_cycle.bus_byte   = ncs_pkg::OpReadStart;
        end else if (i_cmd.opcode == ncs_pkg::OpRndOut) begin
            o_cycle.cycle_kind = ncs_pkg::KindCmd;
            o_cycle.bus_byte   = ncs_pkg::OpRndOutStart;
        end else begin
            o_cycle.cycle_kind = ncs_pkg::KindWait;
            o_cycle.bus_byte   = '0;
        end
    end

endmodule

[src/nand_command_cycle_sequencer_top.sv]
// ----------------------------------------------------------------------------
// nand_command_cycle_sequencer_top
// Expands one large-page NAND command request into its bus cycles.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid, o_in_stall, i_in_data) takes one command
//   request: opcode, optional column and optional page address. The output
//   channel (o_out_valid, i_out_stall, o_out_data) delivers the bus cycles
//   of that command in order, one per clock when not stalled: the opcode
//   latch, two column bytes, RowAddrBytes row bytes, then the opcode tail.
//   The final cycle of a command carries last = 1.
//   The request is held in the request register with the cycle index, and
//   each bus cycle is registered in the output register. The next request
//   is taken in the same clock that the final cycle of the current one
//   enters the output register, so the channel sustains one bus cycle per
//   clock when not stalled.
//   When the receiver stalls, the output register holds its cycle and the
//   counter waits; the input then stalls as well while a command is busy.
//   Reset clears the busy flag and the output valid; no request is pending.
// ----------------------------------------------------------------------------
module nand_command_cycle_sequencer_top #(
    parameter int RowAddrBytes = ncs_pkg::RowAddrBytesDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ncs_pkg::t_cmd   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ncs_pkg::t_cycle o_out_data
);

    localparam int MaxCycles = 3 + RowAddrBytes + 2;
    localparam int StepW     = $clog2(MaxCycles);

    logic              r_busy;
    logic [StepW-1:0]  r_step;
    ncs_pkg::t_cmd     r_cmd;
    logic              r_out_valid;
    ncs_pkg::t_cycle   r_out;

    logic              w_out_free;
    logic              w_load;
    logic              w_in_acc;
    ncs_pkg::t_cycle   w_cyc;

    ncs_cycle_gen #(
        .RowAddrBytes (RowAddrBytes),
        .StepW        (StepW)
    ) u_gen (
        .i_cmd   (r_cmd),
        .i_step  (r_step),
        .o_cycle (w_cyc)
    );

    // Handshake decisions.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load      = r_busy && w_out_free;
    assign o_in_stall  = r_busy && !(w_out_free && w_cyc.last);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Request register and cycle index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (w_in_acc) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (w_load) begin
            if (w_cyc.last) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + StepW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd <= i_in_data;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_cyc;
        end
    end

    // A newly accepted request starts at its command latch.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_busy && r_step == '0))
        else $error("accepted request did not start at cycle zero");

    // The first cycle of every command is a command latch of the opcode.
    a_first_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == '0) |->
            (w_cyc.cycle_kind == ncs_pkg::KindCmd && w_cyc.bus_byte == r_cmd.opcode))
        else $error("first cycle is not the opcode latch");

    // A wait for ready only ever ends a command.
    a_wait_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_cyc.cycle_kind == ncs_pkg::KindWait) |-> w_cyc.last)
        else $error("wait cycle not flagged as last");

    // The index never runs past the longest command.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (int'(r_step) < MaxCycles))
        else $error("cycle index out of range");

    // A cycle that is not the last keeps the command busy.
    a_keep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_cyc.last) |=> r_busy)
        else $error("command dropped before its last cycle");

endmodule

[tb/ncs_cycle_checker.sv]
// ----------------------------------------------------------------------------
// ncs_cycle_checker
// Watches both channels of the NAND command cycle sequencer. Every accepted
// command request is expanded into the bus cycles it must produce, and every
// accepted bus cycle is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
module ncs_cycle_checker
    import ncs_pkg::*;
#(
    parameter int RowBytes = RowAddrBytesDef
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_stall,
    input  t_cmd   i_in_data,
    input  logic   i_out_valid,
    input  logic   i_out_stall,
    input  t_cycle i_out_data,
    output int     o_fail_count,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Bus cycles owed by the block, oldest first.
    t_cycle cycles_due[$];
    t_cycle want;

    function automatic t_cycle make_cycle(input logic [1:0] kind, input logic [7:0] data);
        t_cycle cy;
        cy.cycle_kind = kind;
        cy.bus_byte   = data;
        cy.last       = 1'b0;
        return cy;
    endfunction

    // Expand one command into its command, address and tail cycles.
    task automatic expand_command(input t_cmd cmd);
        t_cycle seq[8];
        int     n;
        n = 0;
        seq[n] = make_cycle(KindCmd, cmd.opcode);
        n++;
        if (cmd.column_present) begin
            seq[n] = make_cycle(KindAddr, cmd.column[7:0]);
            n++;
            seq[n] = make_cycle(KindAddr, cmd.column[15:8]);
            n++;
        end
        if (cmd.page_present) begin
            for (int i = 0; i < RowBytes; i++) begin
                seq[n] = make_cycle(KindAddr, cmd.page[8*i +: 8]);
                n++;
            end
        end
        unique case (cmd.opcode)
            OpPageProg, OpCachedProg, OpErase1, OpErase2, OpSeqIn, OpRndIn, OpStatus: begin
            end
            OpRndOut: begin
                seq[n] = make_cycle(KindCmd, OpRndOutStart);
                n++;
            end
            OpRead0: begin
                seq[n] = make_cycle(KindCmd, OpReadStart);
                n++;
                seq[n] = make_cycle(KindWait, 8'h00);
                n++;
            end
            default: begin
                seq[n] = make_cycle(KindWait, 8'h00);
                n++;
            end
        endcase
        // The final cycle of the command closes it.
        seq[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) begin
            cycles_due.push_back(seq[i]);
        end
    endtask

    // Check delivered cycles first, then record the new request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (cycles_due.size() == 0) begin
                    $display("%0t: unexpected bus cycle kind %0d byte %h last %0d", $time,
                             i_out_data.cycle_kind, i_out_data.bus_byte, i_out_data.last);
                    o_fail_count++;
                end else begin
                    want = cycles_due.pop_front();
                    if (i_out_data.cycle_kind !== want.cycle_kind) begin
                        $display("%0t: cycle_kind expected %0d actual %0d", $time,
                                 want.cycle_kind, i_out_data.cycle_kind);
                        o_fail_count++;
                    end
                    if (i_out_data.bus_byte !== want.bus_byte) begin
                        $display("%0t: bus_byte expected %h actual %h", $time,
                                 want.bus_byte, i_out_data.bus_byte);
                        o_fail_count++;
                    end
                    if (i_out_data.last !== want.last) begin
                        $display("%0t: last expected %0d actual %0d", $time,
                                 want.last, i_out_data.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expand_command(i_in_data);
            end
        end
        o_pending = cycles_due.size();
    end

endmodule

[tb/nand_command_cycle_sequencer_top_tb.sv]
// ----------------------------------------------------------------------------
// nand_command_cycle_sequencer_top_tb
// Drives NAND command requests into the sequencer: a directed set covering
// every tail opcode, both address options and field extremes, then random
// commands. Both channels idle at random; the checker judges the bus cycles.
// ----------------------------------------------------------------------------
module nand_command_cycle_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ncs_pkg::*;

    // Opcodes outside the package that exercise the wait-only tail.
    localparam logic [7:0] OpReset  = 8'hFF;
    localparam logic [7:0] OpReadId = 8'h90;
    localparam int         NumOps   = 13;
    localparam int         NumRandom = 250;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_stall;
    t_cmd   i_in_data;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    t_cycle o_out_data;
    int     fail_count;
    int     cycles_owed;
    logic   steady = 1'b0;

    logic [7:0] tail_ops[NumOps] = '{OpRead0, OpRndOut, OpPageProg, OpCachedProg, OpErase1,
                                     OpErase2, OpSeqIn, OpRndIn, OpStatus, OpReset,
                                     OpReadId, OpReadStart, OpRndOutStart};

    nand_command_cycle_sequencer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    ncs_cycle_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (cycles_owed)
    );

    always #10 i_clk = ~i_clk;

    // The bus side stalls about one cycle in five, except in the steady stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(0, 99) < 20);
    end

    // Offer one request and hold it until the sequencer takes it.
    task automatic send_cmd(input t_cmd cmd);
        while (!steady && ($urandom_range(0, 99) < 20)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    function automatic t_cmd random_cmd();
        t_cmd cmd;
        if ($urandom_range(0, 99) < 65) begin
            cmd.opcode = tail_ops[$urandom_range(0, NumOps - 1)];
        end else begin
            cmd.opcode = 8'($urandom_range(0, 255));
        end
        cmd.column         = 16'($urandom);
        cmd.column_present = 1'($urandom);
        cmd.page           = 24'($urandom);
        cmd.page_present   = 1'($urandom);
        return cmd;
    endfunction

    initial begin
        t_cmd cmd;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every tail opcode, cycling through the address options and extremes.
        for (int i = 0; i < NumOps; i++) begin
            cmd.opcode         = tail_ops[i];
            cmd.column_present = i[0];
            cmd.page_present   = i[1];
            cmd.column         = i[2] ? 16'hFFFF : 16'h0000;
            cmd.page           = i[2] ? 24'hFFFFFF : 24'h000000;
            send_cmd(cmd);
        end
        // Longest command, then the opposite extremes and a mixed pattern with all options on, then a reset with none.
        send_cmd('{opcode: OpRead0, column: 16'hFFFF, column_present: 1'b1,
                   page: 24'hFFFFFF, page_present: 1'b1});
        send_cmd('{opcode: OpRndOut, column: 16'h0000, column_present: 1'b1,
                   page: 24'h000000, page_present: 1'b1});
        send_cmd('{opcode: OpSeqIn, column: 16'hA55A, column_present: 1'b1,
                   page: 24'h5AA55A, page_present: 1'b1});
        send_cmd('{opcode: OpReset, column: 16'hFFFF, column_present: 1'b0,
                   page: 24'hFFFFFF, page_present: 1'b0});

        // Random commands with a stretch of back-to-back traffic in the middle.
        for (int i = 0; i < NumRandom; i++) begin
            steady <= (i >= 100) && (i < 160);
            send_cmd(random_cmd());
        end
        i_in_valid <= 1'b0;
        steady     <= 1'b0;

        // Let the checker record the last request, then drain what is owed.
        @(posedge i_clk);
        while (cycles_owed != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && cycles_owed == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
